### src/flb_pkg.sv
// Shared types, constants and helper functions for the flow hash load balancer.
// Depends on nothing; every other file in src imports it.
`timescale 1ns / 1ps

package flb_pkg;

  // Header geometry. The header arrives as ten little-endian 64-bit words.
  localparam int unsigned HDR_WORDS    = 10;
  localparam int unsigned HDR_BYTES    = HDR_WORDS * 8;
  localparam int unsigned ETH_LEN      = 14;
  localparam int unsigned IP_PROTO_OFF = ETH_LEN + 9;
  localparam int unsigned IP_SRC_OFF   = ETH_LEN + 12;
  localparam int unsigned IP_DST_OFF   = ETH_LEN + 16;
  localparam int unsigned MAC_WORDS    = 6;

  // Field widths.
  localparam int unsigned HASH_W     = 32;
  localparam int unsigned BKT_W      = 4;
  localparam int unsigned GATE_W     = 16;
  localparam int unsigned GCNT_W     = 5;
  localparam int unsigned TAB_REGS   = 4;
  localparam int unsigned TAB_W      = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // Largest number of gates the bucket mapping honors.
  localparam int unsigned GATES_MAX = 16;

  // Reflected Castagnoli polynomial.
  localparam logic [HASH_W-1:0] CRC_POLY = 32'h82F63B78;

  typedef enum logic [1:0] {
    LB_L2 = 2'd0,
    LB_L3 = 2'd1,
    LB_L4 = 2'd2
  } lb_mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LB_MODE    = 3'd0,
    CFG_GATE_COUNT = 3'd1,
    CFG_GATE_TAB_A = 3'd2,
    CFG_GATE_TAB_B = 3'd3,
    CFG_GATE_TAB_C = 3'd4,
    CFG_GATE_TAB_D = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [63:0] hdr_word_9;
    logic [63:0] hdr_word_8;
    logic [63:0] hdr_word_7;
    logic [63:0] hdr_word_6;
    logic [63:0] hdr_word_5;
    logic [63:0] hdr_word_4;
    logic [63:0] hdr_word_3;
    logic [63:0] hdr_word_2;
    logic [63:0] hdr_word_1;
    logic [63:0] hdr_word_0;
  } hdr_req_t;

  typedef struct packed {
    logic [GATE_W-1:0] out_gate;
    logic [BKT_W-1:0]  bucket;
    logic [HASH_W-1:0] flow_hash;
  } gate_rsp_t;

  // Gate selection settings handed to the bucket stage.
  typedef struct packed {
    logic [GCNT_W-1:0]               gate_count;
    logic [TAB_REGS-1:0][TAB_W-1:0]  gate_tab;
  } gate_cfg_t;

  // CRC of a word that has only bit pos set, shifted out over nbits steps.
  // Only evaluated at elaboration to build the columns of the CRC matrix.
  function automatic logic [HASH_W-1:0] crc_col(int unsigned nbits, int unsigned pos);
    logic [HASH_W-1:0] crc;
    crc = HASH_W'(1) << pos;
    for (int unsigned i = 0; i < nbits; i++) begin
      crc = (crc >> 1) ^ (crc[0] ? CRC_POLY : '0);
    end
    return crc;
  endfunction

endpackage

### src/flb_key_hash.sv
// Key extraction and CRC32C for the flow hash load balancer.
// Depends on flb_pkg for the header layout, mode codes and CRC columns.
`timescale 1ns / 1ps

module flb_key_hash
  import flb_pkg::*;
(
  input  hdr_req_t          hdr_i,
  input  logic [1:0]        lb_mode_i,
  output logic [HASH_W-1:0] hash_o
);

  logic [HDR_BYTES*8-1:0] hdr_flat;
  logic [15:0]            key_l2;
  logic [HASH_W-1:0]      key_l3;
  logic [HASH_W-1:0]      key_l4;
  logic [3:0]             ihl;
  logic [9:0]             port_bit;
  logic [31:0]            ports;
  logic [7:0]             proto;
  logic [HASH_W-1:0]      hash16;
  logic [HASH_W-1:0]      hash32;
  logic [HASH_W-1:0]      term16 [16];
  logic [HASH_W-1:0]      term32 [HASH_W];

  assign hdr_flat = {hdr_i.hdr_word_9, hdr_i.hdr_word_8, hdr_i.hdr_word_7,
                     hdr_i.hdr_word_6, hdr_i.hdr_word_5, hdr_i.hdr_word_4,
                     hdr_i.hdr_word_3, hdr_i.hdr_word_2, hdr_i.hdr_word_1,
                     hdr_i.hdr_word_0};

  // MAC key: XOR of the six 16-bit words covering both addresses.
  always_comb begin
    key_l2 = '0;
    for (int unsigned k = 0; k < MAC_WORDS; k++) begin
      key_l2 ^= hdr_flat[16*k +: 16];
    end
  end

  assign key_l3 = hdr_flat[IP_SRC_OFF*8 +: 32] ^ hdr_flat[IP_DST_OFF*8 +: 32];

  // The ports sit right after the IPv4 header, whose length is IHL words.
  assign ihl      = hdr_flat[ETH_LEN*8 +: 4];
  assign port_bit = 10'(ETH_LEN*8) + {1'b0, ihl, 5'b0};
  assign ports    = hdr_flat[port_bit +: 32];
  assign proto    = hdr_flat[IP_PROTO_OFF*8 +: 8];
  assign key_l4   = key_l3 ^ {16'b0, ports[15:0] ^ ports[31:16]} ^ {24'b0, proto};

  // The CRC is linear, so each key bit that is set adds one fixed column.
  for (genvar i = 0; i < 16; i++) begin : g_col16
    localparam logic [HASH_W-1:0] Col = crc_col(16, i);
    assign term16[i] = key_l2[i] ? Col : '0;
  end

  logic [HASH_W-1:0] key_wide;

  always_comb begin
    unique case (lb_mode_i)
      LB_L2:   key_wide = key_l4;
      LB_L3:   key_wide = key_l3;
      LB_L4:   key_wide = key_l4;
      default: key_wide = key_l4;  // mode three hashes like the L4 mode
    endcase
  end

  for (genvar i = 0; i < HASH_W; i++) begin : g_col32
    localparam logic [HASH_W-1:0] Col = crc_col(HASH_W, i);
    assign term32[i] = key_wide[i] ? Col : '0;
  end

  always_comb begin
    hash16 = '0;
    for (int unsigned i = 0; i < 16; i++) begin
      hash16 ^= term16[i];
    end
    hash32 = '0;
    for (int unsigned i = 0; i < HASH_W; i++) begin
      hash32 ^= term32[i];
    end
  end

  assign hash_o = (lb_mode_i == LB_L2) ? hash16 : hash32;

endmodule

### src/flb_gate_pick.sv
// Bucket scaling and gate table lookup for the flow hash load balancer.
// Depends on flb_pkg for widths and the gate settings struct.
`timescale 1ns / 1ps

module flb_gate_pick
  import flb_pkg::*;
(
  input  logic [HASH_W-1:0] hash_i,
  input  gate_cfg_t         cfg_i,
  output logic [BKT_W-1:0]  bucket_o,
  output logic [GATE_W-1:0] gate_o
);

  logic [GCNT_W-1:0]        gate_n;
  logic [HASH_W+GCNT_W-1:0] prod;

  // Counts above the supported maximum behave as the maximum.
  assign gate_n = (cfg_i.gate_count > GCNT_W'(GATES_MAX)) ? GCNT_W'(GATES_MAX)
                                                           : cfg_i.gate_count;

  assign prod     = {{GCNT_W{1'b0}}, hash_i} * {{HASH_W{1'b0}}, gate_n};
  assign bucket_o = prod[HASH_W +: BKT_W];

  assign gate_o = cfg_i.gate_tab[bucket_o[3:2]][{bucket_o[1:0], 4'b0} +: GATE_W];

endmodule

### src/flow_hash_load_balancer.sv
// Top level of the flow hash load balancer: configuration registers and pipeline.
// Depends on flb_pkg, flb_key_hash and flb_gate_pick.
`timescale 1ns / 1ps

// The block takes the first 80 bytes of a packet header per request and returns
// one result per request: the CRC32C flow hash, the bucket it falls in and the
// gate number read from the gate table. It accepts one request every cycle while
// in_stall_o is low. An accepted request sits in the header register while the
// key extraction, the CRC XOR network, the 32 by 5 bit bucket multiply and the
// table lookup run in one combinational pass. The result register takes that
// pass's output once the output stage has room and offers it. A stalled result
// holds the header register only when it is full, so one more request still gets
// in while the output waits.
// Configuration is written through a plain write port and should change only
// while no request is in flight.
module flow_hash_load_balancer
  import flb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,

  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  hdr_req_t              in_req_i,

  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output gate_rsp_t             out_rsp_o,

  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers.
  logic [1:0] lb_mode_q;
  gate_cfg_t  gate_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lb_mode_q             <= LB_L2;
      gate_cfg_q.gate_count <= GCNT_W'(1);
      gate_cfg_q.gate_tab   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_LB_MODE:    lb_mode_q             <= cfg_wdata_i[1:0];
        CFG_GATE_COUNT: gate_cfg_q.gate_count <= cfg_wdata_i[GCNT_W-1:0];
        CFG_GATE_TAB_A: gate_cfg_q.gate_tab[0] <= cfg_wdata_i;
        CFG_GATE_TAB_B: gate_cfg_q.gate_tab[1] <= cfg_wdata_i;
        CFG_GATE_TAB_C: gate_cfg_q.gate_tab[2] <= cfg_wdata_i;
        CFG_GATE_TAB_D: gate_cfg_q.gate_tab[3] <= cfg_wdata_i;
        default: ;  // writes to unknown indexes are dropped
      endcase
    end
  end

  // Pipeline: stage one holds the header, stage two the result.
  logic              v1_q, v1_d, v2_q, v2_d;
  logic              rdy1, rdy2;
  hdr_req_t          hdr_q;
  logic [HASH_W-1:0] hash;
  logic [BKT_W-1:0]  bkt;
  logic [GATE_W-1:0] gate;
  gate_rsp_t         rsp_q;

  // A stage can take new data when it is empty or its content moves on.
  assign rdy2 = !v2_q || !out_stall_i;
  assign rdy1 = !v1_q || rdy2;

  always_comb begin
    v1_d = rdy1 ? in_valid_i : v1_q;
    v2_d = rdy2 ? v1_q : v2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
    end
  end

  flb_key_hash u_key_hash (
    .hdr_i     (hdr_q),
    .lb_mode_i (lb_mode_q),
    .hash_o    (hash)
  );

  flb_gate_pick u_gate_pick (
    .hash_i   (hash),
    .cfg_i    (gate_cfg_q),
    .bucket_o (bkt),
    .gate_o   (gate)
  );

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      hdr_q <= in_req_i;
    end
    if (rdy2 && v1_q) begin
      rsp_q.out_gate  <= gate;
      rsp_q.bucket    <= bkt;
      rsp_q.flow_hash <= hash;
    end
  end

  assign in_stall_o  = !rdy1;
  assign out_valid_o = v2_q;
  assign out_rsp_o   = rsp_q;

`ifndef SYNTHESIS
  // A header held behind a stalled result must not be overwritten.
  a_hdr_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !rdy2) |=> (v1_q && $stable(hdr_q)))
    else $error("header stage lost its content while blocked");

  // The bucket stays below the gate count whenever that count is in range.
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && gate_cfg_q.gate_count != '0 &&
     gate_cfg_q.gate_count <= GCNT_W'(GATES_MAX)) |->
    ({1'b0, bkt} < gate_cfg_q.gate_count))
    else $error("bucket outside the configured gate range");

  // A taken result with nothing behind it leaves the output empty.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !v1_q) |=> !out_valid_o)
    else $error("result repeated after it was taken");
`endif

endmodule
